// ===== src/esd_pkg.sv =====
`timescale 1ns / 1ps

package esd_pkg;

  localparam int ESD_LENGTH_LIMIT = 4096;
  localparam int ESD_QUEUE_DEPTH  = 4;
  localparam int MAX_LEN_W        = 13;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = 13'd1024;

  // Most results one input byte can cause
  localparam int RES_MAX = 3;

  // Raw byte codes with a meaning to the decoder
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;

  typedef enum logic [2:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_ESC,
    MODE_CARET,
    MODE_OCT,
    MODE_HEX,
    MODE_DRAIN
  } mode_t;

  // Results caused by one input beat, slot 0 first
  typedef struct packed {
    logic [1:0]              cnt;
    logic [RES_MAX-1:0][7:0] bytes;
    logic [RES_MAX-1:0]      term;
  } res_entry_t;

endpackage

// ===== src/escape_sequence_string_decoder_core.sv =====
`timescale 1ns / 1ps
// Path: a result is written into the queue when its input beat is accepted, then the
//   back end loads the entry into its output register.
// Throughput: one input beat per cycle while the queue has room; a beat's 0 to 3 results
//   go out singly, so the output port, one per cycle while out_ready holds, sets the rate.
// Reset (rst, synchronous): string state cleared, max_len back to 1024, queue emptied.

module escape_sequence_string_decoder_core import esd_pkg::*; #(
  parameter int LENGTH_LIMIT = ESD_LENGTH_LIMIT,
  parameter int QUEUE_DEPTH  = ESD_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  // raw byte stream
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  // decoded byte stream
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 is_terminator,
  output logic                 run_last,
  // max_len register
  input  logic                 cfg_we,
  input  logic [MAX_LEN_W-1:0] cfg_wdata
);

  logic       q_full;
  logic       push;
  res_entry_t push_data;
  logic       q_valid;
  res_entry_t q_data;
  logic       pop;

  // Front end: decode one raw beat per cycle while the queue has room into up to three results,
  // tracking escape, caret, quote and length state.
  esd_front #(
    .LENGTH_LIMIT(LENGTH_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  // Hold decoded groups so the input side keeps moving while the output stalls
  esd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .pop      (pop)
  );

  // Back end: send each group out one result beat at a time, flagging the last
  esd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .is_terminator(is_terminator),
    .run_last     (run_last)
  );

endmodule

// ===== src/esd_front.sv =====
`timescale 1ns / 1ps

module esd_front import esd_pkg::*; #(
  parameter int LENGTH_LIMIT = ESD_LENGTH_LIMIT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  input  logic                 cfg_we,
  input  logic [MAX_LEN_W-1:0] cfg_wdata,
  input  logic                 q_full,
  output logic                 push,
  output res_entry_t           push_data
);

  localparam int CW = $clog2(LENGTH_LIMIT + 1);
  localparam int WW = (CW > MAX_LEN_W) ? CW : MAX_LEN_W;
  localparam logic [WW-1:0] LIMIT_W = WW'(LENGTH_LIMIT);

  typedef struct packed {
    mode_t         mode;
    logic [7:0]    quote;
    logic [7:0]    val;
    logic [CW-1:0] cnt;
    logic [1:0]    dig;
    res_entry_t    ent;
  } dec_t;

  mode_t                mode;
  logic [7:0]           quote_char;
  logic [7:0]           escape_value;
  logic [CW-1:0]        written_count;
  logic [1:0]           digit_count;
  logic [MAX_LEN_W-1:0] max_len;
  logic [CW-1:0]        cap;
  dec_t                 cur;
  dec_t                 st_next;
  logic                 accept;

  function automatic dec_t f_push(dec_t s, logic [7:0] b, logic t);
    if (s.ent.cnt != 2'(RES_MAX)) begin
      s.ent.bytes[s.ent.cnt] = b;
      s.ent.term[s.ent.cnt]  = t;
      s.ent.cnt              = s.ent.cnt + 2'd1;
    end
    return s;
  endfunction

  function automatic dec_t f_finish(dec_t s);
    s      = f_push(s, 8'h00, 1'b1);
    s.mode = MODE_DRAIN;
    return s;
  endfunction

  function automatic dec_t f_emit(dec_t s, logic [7:0] b, logic [CW-1:0] c);
    s     = f_push(s, b, 1'b0);
    s.cnt = s.cnt + CW'(1);
    if (s.cnt >= c) s = f_finish(s);
    return s;
  endfunction

  function automatic dec_t f_plain(dec_t s, logic [7:0] b, logic [CW-1:0] c);
    if (b == CH_BSLASH) s.mode = MODE_ESC;
    else if (b == CH_CARET) s.mode = MODE_CARET;
    else if (s.quote != 8'h00 && b == s.quote) s = f_finish(s);
    else s = f_emit(s, b, c);
    return s;
  endfunction

  // {valid, digit value}
  function automatic logic [4:0] f_hex(logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h57;
    else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h37;
    else return 5'b0_0000;
    return {1'b1, d[3:0]};
  endfunction

  function automatic dec_t f_decode(dec_t s, logic [7:0] b, logic [CW-1:0] c);
    logic [4:0] h;
    h = f_hex(b);
    unique case (s.mode)
      MODE_START: begin
        s.mode = MODE_PLAIN;
        if (b == CH_DQUOTE || b == CH_SQUOTE) s.quote = b;
        else s = f_plain(s, b, c);
      end
      MODE_PLAIN: s = f_plain(s, b, c);
      MODE_ESC: begin
        s.mode = MODE_PLAIN;
        unique case (b)
          8'h61: s = f_emit(s, 8'h07, c);   // a
          8'h62: s = f_emit(s, 8'h08, c);   // b
          8'h66: s = f_emit(s, 8'h0c, c);   // f
          8'h6e: s = f_emit(s, 8'h0a, c);   // n
          8'h72: s = f_emit(s, 8'h0d, c);   // r
          8'h74: s = f_emit(s, 8'h09, c);   // t
          CH_BSLASH: s = f_emit(s, CH_BSLASH, c);
          8'h78: begin                      // x
            s.mode = MODE_HEX;
            s.val  = 8'h00;
            s.dig  = 2'd0;
          end
          default: begin
            if (b >= 8'h30 && b <= 8'h37) begin
              s.mode = MODE_OCT;
              s.val  = b - 8'h30;
              s.dig  = 2'd1;
            end else if (s.quote != 8'h00 && b == s.quote) begin
              s = f_emit(s, b, c);
            end else begin
              s = f_plain(s, b, c);
            end
          end
        endcase
      end
      MODE_CARET: begin
        s.mode = MODE_PLAIN;
        if (b >= 8'h41 && b <= 8'h5a) s = f_emit(s, b - 8'h40, c);
        else if (b >= 8'h61 && b <= 8'h7a) s = f_emit(s, b - 8'h60, c);
        else if (b == 8'h5b) s = f_emit(s, 8'h1b, c);
        else if (b == CH_BSLASH) s = f_emit(s, 8'h1c, c);
        else if (b == 8'h5d) s = f_emit(s, 8'h1d, c);
        else if (b == CH_CARET) s = f_emit(s, 8'h1e, c);
        else if (b == 8'h2d) s = f_emit(s, 8'h1f, c);
      end
      MODE_OCT: begin
        if (b >= 8'h30 && b <= 8'h37) begin
          s.val = {s.val[4:0], b[2:0]};
          s.dig = s.dig + 2'd1;
          if (s.dig == 2'd3) begin
            s.mode = MODE_PLAIN;
            s.dig  = 2'd0;
            s      = f_emit(s, s.val, c);
          end
        end else begin
          s.mode = MODE_PLAIN;
          s.dig  = 2'd0;
          s      = f_emit(s, s.val, c);
          if (s.mode != MODE_DRAIN) s = f_plain(s, b, c);
        end
      end
      MODE_HEX: begin
        if (h[4]) begin
          s.val = {s.val[3:0], h[3:0]};
          s.dig = 2'd1;
        end else begin
          s.mode = MODE_PLAIN;
          if (s.dig != 2'd0) s = f_emit(s, s.val, c);
          s.dig = 2'd0;
          if (s.mode != MODE_DRAIN) s = f_plain(s, b, c);
        end
      end
      default: s.mode = MODE_DRAIN;
    endcase
    return s;
  endfunction

  function automatic dec_t f_step(dec_t s, logic [7:0] b, logic last, logic [CW-1:0] c);
    if (s.mode != MODE_DRAIN && s.cnt >= c) s = f_finish(s);
    else s = f_decode(s, b, c);
    if (last) begin
      if (s.mode == MODE_OCT || (s.mode == MODE_HEX && s.dig != 2'd0)) begin
        s = f_emit(s, s.val, c);
      end
      if (s.mode != MODE_DRAIN) s = f_finish(s);
      s.mode  = MODE_START;
      s.quote = 8'h00;
      s.val   = 8'h00;
      s.cnt   = '0;
      s.dig   = 2'd0;
    end
    return s;
  endfunction

  // Clamp the length register to the build limit
  always_comb begin
    if (WW'(max_len) > LIMIT_W) cap = CW'(LENGTH_LIMIT);
    else cap = CW'(max_len);
  end

  // Next state
  always_comb begin
    cur.mode  = mode;
    cur.quote = quote_char;
    cur.val   = escape_value;
    cur.cnt   = written_count;
    cur.dig   = digit_count;
    cur.ent   = '0;
    st_next   = f_step(cur, in_byte, in_last, cap);
  end

  // Outputs
  always_comb begin
    in_ready  = !q_full;
    accept    = in_valid && in_ready;
    push      = accept && (st_next.ent.cnt != 2'd0);
    push_data = st_next.ent;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_START;
      quote_char    <= 8'h00;
      escape_value  <= 8'h00;
      written_count <= '0;
      digit_count   <= 2'd0;
      max_len       <= MAX_LEN_RESET;
    end else begin
      if (cfg_we) max_len <= cfg_wdata;
      if (accept) begin
        mode          <= st_next.mode;
        quote_char    <= st_next.quote;
        escape_value  <= st_next.val;
        written_count <= st_next.cnt;
        digit_count   <= st_next.dig;
      end
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> mode == MODE_START && written_count == '0)
    else $error("string state not cleared after last beat");

  // A string already ended by its terminator gives nothing on its last beat
  a_last_pushes_term: assert property (@(posedge clk) disable iff (rst)
    accept && in_last && mode != MODE_DRAIN |->
      push && st_next.ent.term[st_next.ent.cnt - 2'd1])
    else $error("last beat did not end in a terminator");

  a_count_capped: assert property (@(posedge clk) disable iff (rst)
    written_count <= CW'(LENGTH_LIMIT))
    else $error("written count beyond length limit");

endmodule

// ===== src/esd_queue.sv =====
`timescale 1ns / 1ps

module esd_queue import esd_pkg::*; #(
  parameter int DEPTH = ESD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  res_entry_t push_data,
  output logic       full,
  output logic       q_valid,
  output res_entry_t q_data,
  input  logic       pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  res_entry_t      mem [DEPTH];
  logic [PW-1:0]   wptr;
  logic [PW-1:0]   rptr;
  logic [NW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = (count == NW'(DEPTH));
  assign q_valid = (count != '0);
  assign q_data  = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (do_pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      if (do_push && !do_pop) count <= count + NW'(1);
      else if (do_pop && !do_push) count <= count - NW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("push into full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("queue count out of range");

  a_no_empty_entry: assert property (@(posedge clk) disable iff (rst)
    push |-> push_data.cnt != 2'd0)
    else $error("empty entry pushed");

endmodule

// ===== src/esd_back.sv =====
`timescale 1ns / 1ps

module esd_back import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  res_entry_t q_data,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       is_terminator,
  output logic       run_last
);

  res_entry_t cur;
  logic       busy;
  logic [1:0] idx;
  logic       at_last;
  logic       take;

  assign at_last       = (idx == cur.cnt - 2'd1);
  assign out_valid     = busy;
  assign out_byte      = cur.bytes[idx];
  assign is_terminator = cur.term[idx];
  assign run_last      = at_last;
  assign take          = out_valid && out_ready;
  // Load the next entry when idle or when the final beat of this one leaves
  assign pop           = q_valid && (!busy || (take && at_last));

  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (take) begin
      if (at_last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  a_idx_in_entry: assert property (@(posedge clk) disable iff (rst)
    busy |-> cur.cnt != 2'd0 && idx < cur.cnt)
    else $error("result index outside current entry");

  a_term_is_zero: assert property (@(posedge clk) disable iff (rst)
    busy && is_terminator |-> out_byte == 8'h00 && run_last)
    else $error("terminator carries data or is not last");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import esd_pkg::*;

  // Cycles to hold after the last expected result before a register write or
  // the end of the run: a comfortable margin for beats that cause no result.
  localparam int DRAIN_CYCLES = 8;
  // Cycles with no beat on either side before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       term;
    logic       last;
  } dec_res_t;

  // Expected results typed into the directed table; typed = 0 means the
  // predictor supplies them.
  typedef struct packed {
    logic                  typed;
    logic [1:0]            n;
    dec_res_t [RES_MAX-1:0] res;
  } beat_note_t;

  typedef enum logic {
    ROW_BEAT,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [MAX_LEN_W-1:0] cfg;
    logic [7:0]           b;
    logic                 last;
    beat_note_t           note;
  } row_t;

  localparam beat_note_t PREDICTED = '0;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_byte   = 8'h00;
  logic                 in_last   = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_byte;
  logic                 is_terminator;
  logic                 run_last;
  logic                 cfg_we    = 1'b0;
  logic [MAX_LEN_W-1:0] cfg_wdata = '0;

  escape_sequence_string_decoder_core u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .is_terminator (is_terminator),
    .run_last      (run_last),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder predictor: its own copy of the string state and of max_len.
  // ---------------------------------------------------------------------------
  mode_t                dec_mode;
  logic [7:0]           quote_ch;
  logic [7:0]           esc_val;
  int unsigned          dec_count;   // decoded bytes written in this string
  int unsigned          dig_cnt;
  int unsigned          len_cap;
  logic [MAX_LEN_W-1:0] max_len_q;
  dec_res_t             beat_res [RES_MAX];
  int                   beat_cnt;

  dec_res_t   decoded_q [$];   // decoded bytes still owed by the block
  beat_note_t note_q [$];      // one note per beat offered, popped on accept
  logic [7:0] raw_q [$];       // raw string being sent
  bit         steady = 1'b0;   // no idling on either side while set
  int         mismatches = 0;
  int         quiet_cycles = 0;

  function automatic void add_res(logic [7:0] d, logic t);
    // a beat never causes more than three results; drop any beyond
    if (beat_cnt < RES_MAX) begin
      beat_res[beat_cnt].data = d;
      beat_res[beat_cnt].term = t;
      beat_res[beat_cnt].last = 1'b0;
      beat_cnt++;
    end
  endfunction

  function automatic void end_string();
    add_res(8'h00, 1'b1);
    dec_mode = MODE_DRAIN;
  endfunction

  function automatic void put_byte(logic [7:0] d);
    add_res(d, 1'b0);
    dec_count++;
    // the terminator follows the last byte that fits, in the same beat
    if (dec_count >= len_cap) end_string();
  endfunction

  function automatic void clear_string();
    dec_mode  = MODE_START;
    quote_ch  = 8'h00;
    esc_val   = 8'h00;
    dec_count = 0;
    dig_cnt   = 0;
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    if (b == CH_BSLASH) dec_mode = MODE_ESC;
    else if (b == CH_CARET) dec_mode = MODE_CARET;
    else if (quote_ch != 8'h00 && b == quote_ch) end_string();
    else put_byte(b);
  endfunction

  function automatic int hex_digit(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int h;
    case (dec_mode)
      MODE_START: begin
        // an opening quote is swallowed and picks the closing character
        dec_mode = MODE_PLAIN;
        if (b == CH_DQUOTE || b == CH_SQUOTE) quote_ch = b;
        else plain_byte(b);
      end
      MODE_PLAIN: plain_byte(b);
      MODE_ESC: begin
        dec_mode = MODE_PLAIN;
        case (b)
          "a":       put_byte(8'h07);
          "b":       put_byte(8'h08);
          "f":       put_byte(8'h0c);
          "n":       put_byte(8'h0a);
          "r":       put_byte(8'h0d);
          "t":       put_byte(8'h09);
          CH_BSLASH: put_byte(CH_BSLASH);
          "x": begin
            dec_mode = MODE_HEX;
            esc_val  = 8'h00;
            dig_cnt  = 0;
          end
          default: begin
            if (b >= "0" && b <= "7") begin
              dec_mode = MODE_OCT;
              esc_val  = b - "0";
              dig_cnt  = 1;
            end else if (quote_ch != 8'h00 && b == quote_ch) begin
              put_byte(b);
            end else begin
              // unknown escape: drop the backslash, decode the byte as is
              plain_byte(b);
            end
          end
        endcase
      end
      MODE_CARET: begin
        dec_mode = MODE_PLAIN;
        // any other byte after a caret vanishes together with the caret
        if (b >= "A" && b <= "Z") put_byte(b - "@");
        else if (b >= "a" && b <= "z") put_byte(b - 8'h60);
        else if (b == "[") put_byte(8'h1b);
        else if (b == CH_BSLASH) put_byte(8'h1c);
        else if (b == "]") put_byte(8'h1d);
        else if (b == CH_CARET) put_byte(8'h1e);
        else if (b == "-") put_byte(8'h1f);
      end
      MODE_OCT: begin
        if (b >= "0" && b <= "7") begin
          esc_val = {esc_val[4:0], b[2:0]};
          dig_cnt++;
          if (dig_cnt >= 3) begin
            dec_mode = MODE_PLAIN;
            dig_cnt  = 0;
            put_byte(esc_val);
          end
        end else begin
          // a non-digit closes the number, then decodes on its own
          dec_mode = MODE_PLAIN;
          dig_cnt  = 0;
          put_byte(esc_val);
          if (dec_mode != MODE_DRAIN) plain_byte(b);
        end
      end
      MODE_HEX: begin
        h = hex_digit(b);
        if (h >= 0) begin
          esc_val = {esc_val[3:0], h[3:0]};
          dig_cnt = 1;
        end else begin
          dec_mode = MODE_PLAIN;
          if (dig_cnt != 0) put_byte(esc_val);
          dig_cnt = 0;
          if (dec_mode != MODE_DRAIN) plain_byte(b);
        end
      end
      default: dec_mode = MODE_DRAIN;
    endcase
  endfunction

  function automatic void predict_beat(logic [7:0] b, logic last);
    beat_cnt = 0;
    len_cap  = (max_len_q > ESD_LENGTH_LIMIT) ? ESD_LENGTH_LIMIT : max_len_q;
    // a limit already met (or lowered below the count) ends the string here
    if (dec_mode != MODE_DRAIN && dec_count >= len_cap) end_string();
    else decode_byte(b);
    if (last) begin
      // flush a pending number, then close whatever is still open
      if (dec_mode == MODE_OCT || (dec_mode == MODE_HEX && dig_cnt != 0)) put_byte(esc_val);
      if (dec_mode != MODE_DRAIN) end_string();
      clear_string();
    end
    if (beat_cnt > 0) beat_res[beat_cnt-1].last = 1'b1;
  endfunction

  function automatic void flag_mismatch(dec_res_t want, dec_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $write("mismatch at %0t: expected byte %02h term %0b run_last %0b,",
             $realtime, want.data, want.term, want.last);
      $display(" got byte %02h term %0b run_last %0b", got.data, got.term, got.last);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every output beat.
  // Both are sampled here at the same edge, so the order is fixed.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    beat_note_t note;
    dec_res_t   got;
    dec_res_t   want;
    if (rst) begin
      max_len_q = MAX_LEN_RESET;
      clear_string();
      decoded_q.delete();
    end else begin
      if (cfg_we) max_len_q = cfg_wdata;
      if (in_valid && in_ready) begin
        note = note_q.pop_front();
        predict_beat(in_byte, in_last);
        // the predictor always runs to keep its state; typed rows override it
        if (note.typed) begin
          for (int i = 0; i < int'(note.n); i++) decoded_q.push_back(note.res[i]);
        end else begin
          for (int i = 0; i < beat_cnt; i++) decoded_q.push_back(beat_res[i]);
        end
      end
      if (out_valid && out_ready) begin
        got.data = out_byte;
        got.term = is_terminator;
        got.last = run_last;
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result at %0t: byte %02h term %0b run_last %0b",
                     $realtime, got.data, got.term, got.last);
          end
        end else begin
          want = decoded_q.pop_front();
          if (got.data != want.data || got.term != want.term || got.last != want.last) begin
            flag_mismatch(want, got);
          end
        end
      end
      // watchdog: count cycles in which no beat moves on either side
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Idling: mostly short gaps, a few long ones, none while steady is set.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Receiver: stall at random, then take a burst of results.
  initial begin : sink
    int gap;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Offer one beat and hold it until accepted. Valid is lowered only for a
  // gap, never dropped and raised again in the same step.
  task automatic send_beat(input logic [7:0] b, input logic last, input beat_note_t note);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note_q.push_back(note);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and wait until every owed result has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (decoded_q.size() != 0 || note_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [MAX_LEN_W-1:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char(string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  // Build one raw string: mostly well-formed escapes with random content,
  // some noise bytes, stray quotes and trailing escape starters.
  function automatic void build_string();
    int         n_tok;
    int         r;
    logic [7:0] q;
    raw_q.delete();
    r = $urandom_range(0, 99);
    q = (r < 30) ? CH_DQUOTE : (r < 45) ? CH_SQUOTE : 8'h00;
    if (q != 8'h00) raw_q.push_back(q);
    n_tok = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 7);
    for (int t = 0; t < n_tok; t++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        raw_q.push_back(pick_char("abcdefghijklmnopqrstuvwxyz ABCDXYZ0123456789.,!?{}"));
      end else if (r < 47) begin
        raw_q.push_back(CH_BSLASH);
        raw_q.push_back(pick_char("abfnrt\\"));
      end else if (r < 55) begin
        raw_q.push_back(CH_BSLASH);
        raw_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 65) begin
        raw_q.push_back(CH_BSLASH);
        repeat ($urandom_range(1, 3)) raw_q.push_back(pick_char("01234567"));
      end else if (r < 75) begin
        raw_q.push_back(CH_BSLASH);
        raw_q.push_back("x");
        repeat ($urandom_range(0, 4)) raw_q.push_back(pick_char("0123456789abcdefABCDEF"));
      end else if (r < 85) begin
        raw_q.push_back(CH_CARET);
        if ($urandom_range(0, 4) == 0) raw_q.push_back(8'($urandom_range(0, 255)));
        else raw_q.push_back(pick_char("AMZamz[\\]^-"));
      end else if (r < 90) begin
        // escaped quote, or a bare one that may close the string early
        if (q != 8'h00 && $urandom_range(0, 1) == 1) raw_q.push_back(CH_BSLASH);
        raw_q.push_back((q != 8'h00) ? q : pick_char("\"'"));
      end else begin
        raw_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    r = $urandom_range(0, 99);
    if (r < 8) raw_q.push_back(CH_BSLASH);
    else if (r < 14) raw_q.push_back(CH_CARET);
    else if (r < 40 && q != 8'h00) raw_q.push_back(q);
  endfunction

  function automatic beat_note_t typed_note(int n, logic [7:0] d0, logic t0,
                                            logic [7:0] d1, logic t1);
    beat_note_t note;
    note        = '0;
    note.typed  = 1'b1;
    note.n      = 2'(n);
    note.res[0] = '{data: d0, term: t0, last: (n == 1)};
    note.res[1] = '{data: d1, term: t1, last: (n == 2)};
    return note;
  endfunction

  row_t dir_rows [$];

  function automatic void add_beat(logic [7:0] b, logic last, beat_note_t note);
    row_t row;
    row      = '0;
    row.kind = ROW_BEAT;
    row.b    = b;
    row.last = last;
    row.note = note;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(logic [MAX_LEN_W-1:0] v);
    row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.cfg  = v;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stim
    logic [MAX_LEN_W-1:0] setting;
    int                   sent;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Quoted string under the reset limit: swallowed opening quote, byte
    // extremes, escaped quote.
    add_beat(CH_DQUOTE, 1'b0, typed_note(0, 8'h00, 1'b0, 8'h00, 1'b0));
    add_beat(8'h00,     1'b0, typed_note(1, 8'h00, 1'b0, 8'h00, 1'b0));
    add_beat(8'hff,     1'b0, typed_note(1, 8'hff, 1'b0, 8'h00, 1'b0));
    add_beat(CH_BSLASH, 1'b0, typed_note(0, 8'h00, 1'b0, 8'h00, 1'b0));
    add_beat(CH_DQUOTE, 1'b0, typed_note(1, CH_DQUOTE, 1'b0, 8'h00, 1'b0));
    // unknown escape
    add_beat(CH_BSLASH, 1'b0, PREDICTED);
    add_beat("q",       1'b0, PREDICTED);
    // hex escape with no digits
    add_beat(CH_BSLASH, 1'b0, PREDICTED);
    add_beat("x",       1'b0, PREDICTED);
    add_beat("g",       1'b0, PREDICTED);
    // octal closed by a non-octal digit
    add_beat(CH_BSLASH, 1'b0, PREDICTED);
    add_beat("1",       1'b0, PREDICTED);
    add_beat("0",       1'b0, PREDICTED);
    add_beat("8",       1'b0, PREDICTED);
    // unknown caret swallows even the closing quote
    add_beat(CH_CARET,  1'b0, PREDICTED);
    add_beat(CH_DQUOTE, 1'b0, PREDICTED);
    add_beat(CH_CARET,  1'b0, PREDICTED);
    add_beat("[",       1'b0, PREDICTED);
    // octal value flushed by the closing quote on the last beat
    add_beat(CH_BSLASH, 1'b0, PREDICTED);
    add_beat("7",       1'b0, PREDICTED);
    add_beat(CH_DQUOTE, 1'b1, PREDICTED);
    // unquoted string, hex still pending at the last beat
    add_beat(CH_BSLASH, 1'b0, PREDICTED);
    add_beat("x",       1'b0, PREDICTED);
    add_beat("4",       1'b0, PREDICTED);
    add_beat("F",       1'b1, PREDICTED);
    // trailing caret: dropped, only the terminator
    add_beat(CH_CARET,  1'b1, typed_note(1, 8'h00, 1'b1, 8'h00, 1'b0));
    // zero length: terminator on the first byte, rest drained
    add_cfg(13'd0);
    add_beat("z",       1'b0, typed_note(1, 8'h00, 1'b1, 8'h00, 1'b0));
    add_beat("y",       1'b1, typed_note(0, 8'h00, 1'b0, 8'h00, 1'b0));
    // length reached on the second byte
    add_cfg(13'd2);
    add_beat("a",       1'b0, typed_note(1, "a", 1'b0, 8'h00, 1'b0));
    add_beat("b",       1'b0, typed_note(2, "b", 1'b0, 8'h00, 1'b1));
    add_beat("c",       1'b0, typed_note(0, 8'h00, 1'b0, 8'h00, 1'b0));
    add_beat("d",       1'b1, typed_note(0, 8'h00, 1'b0, 8'h00, 1'b0));
    // limit lowered below the count in the middle of a string
    add_cfg(13'h1fff);
    add_beat("a",       1'b0, PREDICTED);
    add_beat("b",       1'b0, PREDICTED);
    add_beat("c",       1'b0, PREDICTED);
    add_cfg(13'd1);
    add_beat("d",       1'b0, typed_note(1, 8'h00, 1'b1, 8'h00, 1'b0));
    add_beat("e",       1'b1, typed_note(0, 8'h00, 1'b0, 8'h00, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_max_len(dir_rows[i].cfg);
      else send_beat(dir_rows[i].b, dir_rows[i].last, dir_rows[i].note);
    end

    // Random strings over a spread of limits, extremes included.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       setting = 13'd1;
        1:       setting = 13'd0;
        2:       setting = 13'd4096;
        3:       setting = 13'h1fff;
        4:       setting = 13'd5;
        5:       setting = 13'd2;
        6:       setting = MAX_LEN_RESET;
        7:       setting = 13'($urandom_range(0, 8191));
        8:       setting = 13'($urandom_range(1, 12));
        default: setting = 13'd16;
      endcase
      write_max_len(setting);
      steady = (ph % 4 == 3);
      sent = 0;
      while (sent < 36) begin
        build_string();
        foreach (raw_q[k]) send_beat(raw_q[k], k == raw_q.size() - 1, PREDICTED);
        sent += raw_q.size();
        // now and then hold off until the block has answered everything
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end

    steady = 1'b0;
    wait_idle();
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/esd_pkg.sv
src/esd_front.sv
src/esd_queue.sv
src/esd_back.sv
src/escape_sequence_string_decoder_core.sv
dv/testbench.sv
